/* rtl/rcsd_pkg.sv */
package rcsd_pkg;

   localparam int CH_W     = 11;
   localparam int SPD_W    = 12;
   localparam int OUT_W    = 13;
   localparam int PULSE_W  = 11;
   localparam int TRIG_W   = 10;
   localparam int SW_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam int CHANNEL_MID = 1024;
   localparam int CHANNEL_MIN = 364;
   localparam int CHANNEL_MAX = 1684;

   localparam logic [CH_W-1:0] HI_EDGE = CH_W'(CHANNEL_MID + 2);
   localparam logic [CH_W-1:0] LO_EDGE = CH_W'(CHANNEL_MID - 2);

   localparam int GUARD_CENTER = 1024;
   localparam int GUARD_SPAN   = 60;
   localparam logic [CH_W-1:0] GUARD_LO = CH_W'(GUARD_CENTER - GUARD_SPAN);
   localparam logic [CH_W-1:0] GUARD_HI = CH_W'(GUARD_CENTER + GUARD_SPAN);

   localparam int POS_DEN_RAW = CHANNEL_MAX - (CHANNEL_MID + 2);
   localparam int NEG_DEN_RAW = (CHANNEL_MID - 2) - CHANNEL_MIN;
   localparam int POS_DEN = (POS_DEN_RAW > 0) ? POS_DEN_RAW : 1;
   localparam int NEG_DEN = (NEG_DEN_RAW > 0) ? NEG_DEN_RAW : 1;
   localparam int DEN_W   = CH_W;

   // quotient estimate by reciprocal, low by at most one
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam longint unsigned POS_RECIP = (64'd1 << RECIP_SHIFT) / POS_DEN;
   localparam longint unsigned NEG_RECIP = (64'd1 << RECIP_SHIFT) / NEG_DEN;

   localparam int P_W    = CH_W + SPD_W;
   localparam int WIDE_W = P_W + RECIP_W;
   localparam int REM_W  = P_W + DEN_W;

   localparam logic [PULSE_W-1:0] PULSE_NEUTRAL   = PULSE_W'(1500);
   localparam logic [SPD_W-1:0]   PITCH_UP_SPAN   = SPD_W'(210);
   localparam logic [SPD_W-1:0]   PITCH_DOWN_SPAN = SPD_W'(105);
   localparam logic [TRIG_W-1:0]  TRIG_ON         = TRIG_W'(1000);
   localparam logic [TRIG_W-1:0]  TRIG_OFF        = TRIG_W'(0);
   localparam logic [PULSE_W-1:0] FRICTION_SLOW   = PULSE_W'(1000);
   localparam logic [PULSE_W-1:0] FRICTION_FAST   = PULSE_W'(1500);

   typedef enum logic [SW_W-1:0] {
      SW_HOLD = 2'd0,
      SW_POS1 = 2'd1,
      SW_POS2 = 2'd2,
      SW_POS3 = 2'd3
   } switch_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REMOTE_SOURCE    = 3'd0,
      CSR_MODE_WINDOW_LOW  = 3'd1,
      CSR_MODE_WINDOW_HIGH = 3'd2,
      CSR_STOP_WINDOW_LOW  = 3'd3,
      CSR_STOP_WINDOW_HIGH = 3'd4,
      CSR_MAX_LINEAR       = 3'd5,
      CSR_MAX_ROTATIONAL   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic       stop;
      logic       guard;
      switch_type sw;
   } frame_type;

   typedef struct packed {
      logic load2;
      logic load3;
   } lane_ctl_type;

   function automatic logic signed [OUT_W-1:0] to_speed(input logic [SPD_W-1:0] mag,
                                                          input logic negate);
      logic signed [OUT_W-1:0] v;
      v = signed'({1'b0, mag});
      return negate ? -v : v;
   endfunction

endpackage

/* rtl/rcsd_front.sv */
module rcsd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        load,
   input  logic [rcsd_pkg::CH_W-1:0]   mode_channel,
   input  logic [rcsd_pkg::CH_W-1:0]   stop_channel,
   input  logic [rcsd_pkg::CH_W-1:0]   x_channel,
   input  logic [rcsd_pkg::CH_W-1:0]   y_channel,
   input  logic [rcsd_pkg::CH_W-1:0]   pitch_channel,
   input  logic [rcsd_pkg::CH_W-1:0]   rotation_channel,
   input  logic [rcsd_pkg::SW_W-1:0]   trigger_switch,
   input  logic [rcsd_pkg::CH_W-1:0]   mode_window_low,
   input  logic [rcsd_pkg::CH_W-1:0]   mode_window_high,
   input  logic [rcsd_pkg::CH_W-1:0]   stop_window_low,
   input  logic [rcsd_pkg::CH_W-1:0]   stop_window_high,
   output logic                        s1_valid,
   output rcsd_pkg::frame_type         s1_frame,
   output logic [rcsd_pkg::CH_W-1:0]   s1_x,
   output logic [rcsd_pkg::CH_W-1:0]   s1_y,
   output logic [rcsd_pkg::CH_W-1:0]   s1_pitch,
   output logic [rcsd_pkg::CH_W-1:0]   s1_rotation
);

   logic                      valid_ff;
   logic                      valid_in;
   logic                      in_window;
   rcsd_pkg::frame_type       frame_ff;
   rcsd_pkg::frame_type       frame_in;
   logic [rcsd_pkg::CH_W-1:0] x_ff;
   logic [rcsd_pkg::CH_W-1:0] y_ff;
   logic [rcsd_pkg::CH_W-1:0] pitch_ff;
   logic [rcsd_pkg::CH_W-1:0] rotation_ff;

   always_comb begin
      in_window      = (mode_channel > mode_window_low) && (mode_channel < mode_window_high);
      valid_in       = accept && in_window;
      frame_in.stop  = (stop_channel >= stop_window_low) && (stop_channel <= stop_window_high);
      frame_in.guard = (pitch_channel < rcsd_pkg::GUARD_LO) ||
                       (pitch_channel > rcsd_pkg::GUARD_HI);
      frame_in.sw    = rcsd_pkg::switch_type'(trigger_switch);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff    <= frame_in;
         x_ff        <= x_channel;
         y_ff        <= y_channel;
         pitch_ff    <= pitch_channel;
         rotation_ff <= rotation_channel;
      end
   end

   assign s1_valid    = valid_ff;
   assign s1_frame    = frame_ff;
   assign s1_x        = x_ff;
   assign s1_y        = y_ff;
   assign s1_pitch    = pitch_ff;
   assign s1_rotation = rotation_ff;

endmodule

/* rtl/rcsd_lane.sv */
module rcsd_lane (
   input  logic                        clock,
   input  rcsd_pkg::lane_ctl_type      ctl,
   input  logic [rcsd_pkg::CH_W-1:0]   channel,
   input  logic [rcsd_pkg::SPD_W-1:0]  span,
   output logic [rcsd_pkg::SPD_W-1:0]  mag,
   output logic                        neg
);

   logic                          pos_side;
   logic                          neg_side;
   logic [rcsd_pkg::CH_W-1:0]     dev;
   logic [rcsd_pkg::P_W-1:0]      prod_in;
   logic [rcsd_pkg::P_W-1:0]      prod_ff;
   logic                          neg_ff;
   logic [rcsd_pkg::SPD_W-1:0]    span_ff;
   logic [rcsd_pkg::RECIP_W-1:0]  recip;
   logic [rcsd_pkg::WIDE_W-1:0]   wide;
   logic [rcsd_pkg::P_W-1:0]      est_in;
   logic [rcsd_pkg::P_W-1:0]      est_ff;
   logic [rcsd_pkg::P_W-1:0]      prod3_ff;
   logic                          neg3_ff;
   logic [rcsd_pkg::SPD_W-1:0]    span3_ff;
   logic [rcsd_pkg::DEN_W-1:0]    den;
   logic [rcsd_pkg::REM_W-1:0]    rem;
   logic [rcsd_pkg::P_W-1:0]      quot;

   // deadband and product
   always_comb begin
      pos_side = channel >= rcsd_pkg::HI_EDGE;
      neg_side = channel <= rcsd_pkg::LO_EDGE;
      if (pos_side) begin
         dev = channel - rcsd_pkg::HI_EDGE;
      end else if (neg_side) begin
         dev = rcsd_pkg::LO_EDGE - channel;
      end else begin
         dev = '0;
      end
      prod_in = rcsd_pkg::P_W'(dev) * rcsd_pkg::P_W'(span);
   end

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_side;
         span_ff <= span;
      end
   end

   // quotient estimate
   always_comb begin
      recip  = neg_ff ? rcsd_pkg::RECIP_W'(rcsd_pkg::NEG_RECIP)
                      : rcsd_pkg::RECIP_W'(rcsd_pkg::POS_RECIP);
      wide   = rcsd_pkg::WIDE_W'(prod_ff) * rcsd_pkg::WIDE_W'(recip);
      est_in = wide[rcsd_pkg::RECIP_SHIFT +: rcsd_pkg::P_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.load3) begin
         est_ff   <= est_in;
         prod3_ff <= prod_ff;
         neg3_ff  <= neg_ff;
         span3_ff <= span_ff;
      end
   end

   // correction and saturation
   always_comb begin
      den  = neg3_ff ? rcsd_pkg::DEN_W'(rcsd_pkg::NEG_DEN) : rcsd_pkg::DEN_W'(rcsd_pkg::POS_DEN);
      rem  = rcsd_pkg::REM_W'(prod3_ff) -
             rcsd_pkg::REM_W'(est_ff) * rcsd_pkg::REM_W'(den);
      quot = (rem >= rcsd_pkg::REM_W'(den)) ? est_ff + rcsd_pkg::P_W'(1) : est_ff;
      mag  = (quot > rcsd_pkg::P_W'(span3_ff)) ? span3_ff : quot[rcsd_pkg::SPD_W-1:0];
   end

   assign neg = neg3_ff;

endmodule

/* rtl/rc_stick_to_drive_command.sv */
// rc_stick_to_drive_command
// maps one radio receiver frame per word into drive speed, gimbal pitch and
// shooter commands
// req channel: one frame per word (mode, stop, four sticks, trigger switch),
//   accepted on a clock edge with req_valid high and req_stall low
// rsp channel: one command word per frame whose mode channel lies inside the
//   mode window; frames outside it are consumed and give no word
// csr port: csr_write with csr_index and csr_data writes one register in a cycle
// path: a command word shows on rsp_valid once its frame has passed the input
//   register, product, quotient estimate and output register
// throughput: one frame per cycle while req_stall is low; the four stages move
//   independently, so empty stages close up and a frame is still taken while a word waits
// stall: rsp_stall holds the output word and fills the stages behind it;
//   req_stall rises only once all four are full
// reset: clears the pipeline, restores the register defaults and sets the
//   held pitch pulse to 1500, trigger speed to 0 and friction pulse to 1000
module rc_stick_to_drive_command (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rcsd_pkg::CH_W-1:0]           req_mode_channel,
   input  logic [rcsd_pkg::CH_W-1:0]           req_stop_channel,
   input  logic [rcsd_pkg::CH_W-1:0]           req_x_channel,
   input  logic [rcsd_pkg::CH_W-1:0]           req_y_channel,
   input  logic [rcsd_pkg::CH_W-1:0]           req_pitch_channel,
   input  logic [rcsd_pkg::CH_W-1:0]           req_rotation_channel,
   input  logic [rcsd_pkg::SW_W-1:0]           req_trigger_switch,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rcsd_pkg::OUT_W-1:0]   rsp_x_speed,
   output logic signed [rcsd_pkg::OUT_W-1:0]   rsp_y_speed,
   output logic signed [rcsd_pkg::OUT_W-1:0]   rsp_rotation_speed,
   output logic [rcsd_pkg::PULSE_W-1:0]        rsp_pitch_pulse,
   output logic [rcsd_pkg::TRIG_W-1:0]         rsp_feed_speed,
   output logic [rcsd_pkg::PULSE_W-1:0]        rsp_friction_pulse,
   output logic                                rsp_friction_update,
   input  logic                                csr_write,
   input  logic [rcsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rcsd_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic                         remote_source_ff;
   logic [rcsd_pkg::CH_W-1:0]    mode_low_ff;
   logic [rcsd_pkg::CH_W-1:0]    mode_high_ff;
   logic [rcsd_pkg::CH_W-1:0]    stop_low_ff;
   logic [rcsd_pkg::CH_W-1:0]    stop_high_ff;
   logic [rcsd_pkg::SPD_W-1:0]   max_lin_ff;
   logic [rcsd_pkg::SPD_W-1:0]   max_rot_ff;

   logic accept;
   logic out_move;
   logic s3_move;
   logic s2_move;
   logic s1_move;

   logic                       s1_valid;
   rcsd_pkg::frame_type        s1_frame;
   logic [rcsd_pkg::CH_W-1:0]  s1_x;
   logic [rcsd_pkg::CH_W-1:0]  s1_y;
   logic [rcsd_pkg::CH_W-1:0]  s1_pitch;
   logic [rcsd_pkg::CH_W-1:0]  s1_rotation;
   logic [rcsd_pkg::SPD_W-1:0] pitch_span;

   logic                  s2_valid_ff;
   logic                  s3_valid_ff;
   rcsd_pkg::frame_type   s2_frame_ff;
   rcsd_pkg::frame_type   s3_frame_ff;
   rcsd_pkg::lane_ctl_type lane_ctl;

   logic [rcsd_pkg::SPD_W-1:0] x_mag;
   logic [rcsd_pkg::SPD_W-1:0] y_mag;
   logic [rcsd_pkg::SPD_W-1:0] rot_mag;
   logic [rcsd_pkg::SPD_W-1:0] pitch_off;
   logic x_neg;
   logic y_neg;
   logic rot_neg;
   logic pitch_down;

   logic                                rsp_valid_ff;
   logic signed [rcsd_pkg::OUT_W-1:0]   x_speed_ff;
   logic signed [rcsd_pkg::OUT_W-1:0]   y_speed_ff;
   logic signed [rcsd_pkg::OUT_W-1:0]   rot_speed_ff;
   logic                                fupd_ff;
   logic signed [rcsd_pkg::OUT_W-1:0]   x_speed_in;
   logic signed [rcsd_pkg::OUT_W-1:0]   y_speed_in;
   logic signed [rcsd_pkg::OUT_W-1:0]   rot_speed_in;
   logic                                fupd_in;

   logic [rcsd_pkg::PULSE_W-1:0] held_pitch_ff;
   logic [rcsd_pkg::TRIG_W-1:0]  held_trig_ff;
   logic [rcsd_pkg::PULSE_W-1:0] held_fric_ff;
   logic [rcsd_pkg::PULSE_W-1:0] held_pitch_in;
   logic [rcsd_pkg::TRIG_W-1:0]  held_trig_in;
   logic [rcsd_pkg::PULSE_W-1:0] held_fric_in;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         remote_source_ff <= 1'b0;
         mode_low_ff      <= '0;
         mode_high_ff     <= rcsd_pkg::CH_W'(2047);
         stop_low_ff      <= '0;
         stop_high_ff     <= '0;
         max_lin_ff       <= rcsd_pkg::SPD_W'(1000);
         max_rot_ff       <= rcsd_pkg::SPD_W'(1000);
      end else if (csr_write) begin
         case (rcsd_pkg::csr_index_type'(csr_index))
            rcsd_pkg::CSR_REMOTE_SOURCE:    remote_source_ff <= csr_data[0];
            rcsd_pkg::CSR_MODE_WINDOW_LOW:  mode_low_ff  <= csr_data[rcsd_pkg::CH_W-1:0];
            rcsd_pkg::CSR_MODE_WINDOW_HIGH: mode_high_ff <= csr_data[rcsd_pkg::CH_W-1:0];
            rcsd_pkg::CSR_STOP_WINDOW_LOW:  stop_low_ff  <= csr_data[rcsd_pkg::CH_W-1:0];
            rcsd_pkg::CSR_STOP_WINDOW_HIGH: stop_high_ff <= csr_data[rcsd_pkg::CH_W-1:0];
            rcsd_pkg::CSR_MAX_LINEAR:       max_lin_ff   <= csr_data[rcsd_pkg::SPD_W-1:0];
            rcsd_pkg::CSR_MAX_ROTATIONAL:   max_rot_ff   <= csr_data[rcsd_pkg::SPD_W-1:0];
            default: ;
         endcase
      end
   end

   // stage flow
   always_comb begin
      out_move       = !rsp_valid_ff || !rsp_stall;
      s3_move        = !s3_valid_ff || out_move;
      s2_move        = !s2_valid_ff || s3_move;
      s1_move        = !s1_valid || s2_move;
      req_stall      = !s1_move;
      accept         = req_valid && s1_move;
      lane_ctl.load2 = s2_move;
      lane_ctl.load3 = s3_move;
   end

   rcsd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .load             (s1_move),
      .mode_channel     (req_mode_channel),
      .stop_channel     (req_stop_channel),
      .x_channel        (req_x_channel),
      .y_channel        (req_y_channel),
      .pitch_channel    (req_pitch_channel),
      .rotation_channel (req_rotation_channel),
      .trigger_switch   (req_trigger_switch),
      .mode_window_low  (mode_low_ff),
      .mode_window_high (mode_high_ff),
      .stop_window_low  (stop_low_ff),
      .stop_window_high (stop_high_ff),
      .s1_valid         (s1_valid),
      .s1_frame         (s1_frame),
      .s1_x             (s1_x),
      .s1_y             (s1_y),
      .s1_pitch         (s1_pitch),
      .s1_rotation      (s1_rotation)
   );

   assign pitch_span = (s1_pitch >= rcsd_pkg::HI_EDGE) ? rcsd_pkg::PITCH_UP_SPAN
                                                       : rcsd_pkg::PITCH_DOWN_SPAN;

   rcsd_lane u_lane_x (
      .clock   (clock),
      .ctl     (lane_ctl),
      .channel (s1_x),
      .span    (max_lin_ff),
      .mag     (x_mag),
      .neg     (x_neg)
   );

   rcsd_lane u_lane_y (
      .clock   (clock),
      .ctl     (lane_ctl),
      .channel (s1_y),
      .span    (max_lin_ff),
      .mag     (y_mag),
      .neg     (y_neg)
   );

   rcsd_lane u_lane_rot (
      .clock   (clock),
      .ctl     (lane_ctl),
      .channel (s1_rotation),
      .span    (max_rot_ff),
      .mag     (rot_mag),
      .neg     (rot_neg)
   );

   rcsd_lane u_lane_pitch (
      .clock   (clock),
      .ctl     (lane_ctl),
      .channel (s1_pitch),
      .span    (pitch_span),
      .mag     (pitch_off),
      .neg     (pitch_down)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s2_move) begin
            s2_valid_ff <= s1_valid;
         end
         if (s3_move) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         s2_frame_ff <= s1_frame;
      end
      if (s3_move) begin
         s3_frame_ff <= s2_frame_ff;
      end
   end

   // result and held state
   always_comb begin
      x_speed_in    = '0;
      y_speed_in    = '0;
      rot_speed_in  = '0;
      fupd_in       = 1'b0;
      held_pitch_in = held_pitch_ff;
      held_trig_in  = held_trig_ff;
      held_fric_in  = held_fric_ff;
      if (!s3_frame_ff.stop) begin
         x_speed_in = rcsd_pkg::to_speed(x_mag, x_neg);
         y_speed_in = rcsd_pkg::to_speed(y_mag, y_neg ^ !remote_source_ff);
         if (!s3_frame_ff.guard) begin
            rot_speed_in = rcsd_pkg::to_speed(rot_mag, rot_neg ^ remote_source_ff);
         end
         held_pitch_in = pitch_down
            ? rcsd_pkg::PULSE_NEUTRAL + rcsd_pkg::PULSE_W'(pitch_off)
            : rcsd_pkg::PULSE_NEUTRAL - rcsd_pkg::PULSE_W'(pitch_off);
         case (s3_frame_ff.sw)
            rcsd_pkg::SW_POS1: begin
               held_trig_in = rcsd_pkg::TRIG_ON;
               held_fric_in = rcsd_pkg::FRICTION_SLOW;
               fupd_in      = 1'b1;
            end
            rcsd_pkg::SW_POS2: begin
               held_trig_in = rcsd_pkg::TRIG_ON;
               held_fric_in = rcsd_pkg::FRICTION_FAST;
               fupd_in      = 1'b1;
            end
            rcsd_pkg::SW_POS3: begin
               held_trig_in = rcsd_pkg::TRIG_OFF;
               held_fric_in = rcsd_pkg::FRICTION_SLOW;
               fupd_in      = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         held_pitch_ff <= rcsd_pkg::PULSE_NEUTRAL;
         held_trig_ff  <= rcsd_pkg::TRIG_OFF;
         held_fric_ff  <= rcsd_pkg::FRICTION_SLOW;
      end else if (out_move) begin
         rsp_valid_ff <= s3_valid_ff;
         if (s3_valid_ff) begin
            held_pitch_ff <= held_pitch_in;
            held_trig_ff  <= held_trig_in;
            held_fric_ff  <= held_fric_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_move && s3_valid_ff) begin
         x_speed_ff   <= x_speed_in;
         y_speed_ff   <= y_speed_in;
         rot_speed_ff <= rot_speed_in;
         fupd_ff      <= fupd_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_x_speed         = x_speed_ff;
   assign rsp_y_speed         = y_speed_ff;
   assign rsp_rotation_speed  = rot_speed_ff;
   assign rsp_pitch_pulse     = held_pitch_ff;
   assign rsp_feed_speed      = held_trig_ff;
   assign rsp_friction_pulse  = held_fric_ff;
   assign rsp_friction_update = fupd_ff;

endmodule

/* rtl/rcsd_checker.sv */
module rcsd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [rcsd_pkg::OUT_W-1:0]   rsp_x_speed,
   input logic [rcsd_pkg::PULSE_W-1:0]        rsp_pitch_pulse,
   input logic [rcsd_pkg::TRIG_W-1:0]         rsp_feed_speed,
   input logic [rcsd_pkg::PULSE_W-1:0]        rsp_friction_pulse,
   input logic                                rsp_friction_update
);

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_speed) &&
                                 $stable(rsp_pitch_pulse))
      else $error("stalled rsp word changed");

   // held pitch pulse stays within servo limits
   assert property (@(posedge clock) disable iff (reset)
      rsp_pitch_pulse >= rcsd_pkg::PULSE_W'(1290) && rsp_pitch_pulse <= rcsd_pkg::PULSE_W'(1605))
      else $error("pitch pulse out of range");

   // trigger off always pairs with slow friction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_friction_update && rsp_feed_speed == rcsd_pkg::TRIG_OFF
         |-> rsp_friction_pulse == rcsd_pkg::FRICTION_SLOW)
      else $error("trigger off with fast friction");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("rsp word right after reset");

endmodule

bind rc_stick_to_drive_command rcsd_checker u_rcsd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_x_speed         (rsp_x_speed),
   .rsp_pitch_pulse     (rsp_pitch_pulse),
   .rsp_feed_speed      (rsp_feed_speed),
   .rsp_friction_pulse  (rsp_friction_pulse),
   .rsp_friction_update (rsp_friction_update)
);
